### hdl/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared widths, defaults, codes and control types for the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	// fixed field widths
	localparam int ID_W   = 4;
	localparam int WAIT_W = 16;
	localparam int TPS_W  = 8;

	// parameter defaults
	localparam int NUM_PROCS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	// ticks per second after reset
	localparam logic [TPS_W-1:0] TPS_RESET = 8'd60;

	// command opcodes
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ADD  = 1'b1
	} opcode_t;

	// result event kinds
	typedef enum logic [1:0] {
		KIND_ACC  = 2'd0,
		KIND_REF  = 2'd1,
		KIND_NONE = 2'd2,
		KIND_WOKE = 2'd3
	} event_kind_t;

	// per-cell commands from the sequencer
	typedef struct packed {
		logic shl;   // take the right neighbor's entry
		logic dec;   // saturating decrement of the held delta
	} cell_ctl_t;

	// control part of the beat that travels down the chain
	typedef struct packed {
		logic active;  // a beat is present
		logic shift;   // 0: new entry seeking its slot, 1: displaced entry
	} tok_ctl_t;

endpackage

### hdl/dtq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the ordered delta list: holds one entry and passes insert
// beats to its right neighbor, or pulls its neighbor's entry on a dequeue.
// ----------------------------------------------------------------------------
module dtq_cell #(
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dtq_pkg::cell_ctl_t       ctl,
	input  dtq_pkg::tok_ctl_t        tin_ctl,
	input  logic [dtq_pkg::ID_W-1:0] tin_pid,
	input  logic [TIME_BITS-1:0]     tin_time,
	output dtq_pkg::tok_ctl_t        tout_ctl,
	output logic [dtq_pkg::ID_W-1:0] tout_pid,
	output logic [TIME_BITS-1:0]     tout_time,
	input  logic                     nb_valid,
	input  logic [dtq_pkg::ID_W-1:0] nb_pid,
	input  logic [TIME_BITS-1:0]     nb_delta,
	output logic                     valid,
	output logic [dtq_pkg::ID_W-1:0] pid,
	output logic [TIME_BITS-1:0]     delta
);
	import dtq_pkg::*;

	logic                 valid_q;
	logic [ID_W-1:0]      pid_q;
	logic [TIME_BITS-1:0] delta_q;

	logic                 valid_d;
	logic [ID_W-1:0]      pid_d;
	logic [TIME_BITS-1:0] delta_d;
	tok_ctl_t             tout_ctl_d;
	logic [ID_W-1:0]      tout_pid_d;
	logic [TIME_BITS-1:0] tout_time_d;

	tok_ctl_t             tout_ctl_q;
	logic [ID_W-1:0]      tout_pid_q;
	logic [TIME_BITS-1:0] tout_time_q;

	logic take_slot;

	// seeking beat stops here when the slot is empty or expires later
	assign take_slot = !valid_q || (tin_time < delta_q);

	// next entry and outgoing beat
	always_comb begin
		valid_d     = valid_q;
		pid_d       = pid_q;
		delta_d     = delta_q;
		tout_ctl_d  = '0;
		tout_pid_d  = pid_q;
		tout_time_d = delta_q;
		if (ctl.shl) begin
			valid_d = nb_valid;
			pid_d   = nb_pid;
			delta_d = nb_delta;
		end else if (ctl.dec) begin
			if (valid_q && (delta_q != '0)) begin
				delta_d = delta_q - TIME_BITS'(1);
			end
		end else if (tin_ctl.active) begin
			if (tin_ctl.shift) begin
				// displaced entry moves in, old entry moves on
				valid_d           = 1'b1;
				pid_d             = tin_pid;
				delta_d           = tin_time;
				tout_ctl_d.active = valid_q;
				tout_ctl_d.shift  = 1'b1;
			end else if (take_slot) begin
				// new entry lands here, old entry moves on less the new wait
				valid_d           = 1'b1;
				pid_d             = tin_pid;
				delta_d           = tin_time;
				tout_ctl_d.active = valid_q;
				tout_ctl_d.shift  = 1'b1;
				tout_time_d       = delta_q - tin_time;
			end else begin
				// pass the remaining wait to the next slot
				tout_ctl_d.active = 1'b1;
				tout_ctl_d.shift  = 1'b0;
				tout_pid_d        = tin_pid;
				tout_time_d       = tin_time - delta_q;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			tout_ctl_q <= '0;
		end else begin
			valid_q    <= valid_d;
			tout_ctl_q <= tout_ctl_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		pid_q       <= pid_d;
		delta_q     <= delta_d;
		tout_pid_q  <= tout_pid_d;
		tout_time_q <= tout_time_d;
	end

	assign valid     = valid_q;
	assign pid       = pid_q;
	assign delta     = delta_q;
	assign tout_ctl  = tout_ctl_q;
	assign tout_pid  = tout_pid_q;
	assign tout_time = tout_time_q;

endmodule

### hdl/delta_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue
// Sleep timer queue kept as an ordered row of cells, each holding one entry
// with its wait relative to the entry ahead of it.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | beat taken when
//  ---------+-------------------------------------------+-------------------
//  command  | start, busy, opcode, process_id,          | start && !busy
//           | wait_seconds                              |
//  result   | done, event_kind, woken_id, last          | done (one cycle)
//  config   | cfg_we, cfg_wdata (ticks_per_second)      | cfg_we
//
// An accepted add is answered at once; its insert beat then walks the full
// row of cells, one cell per cycle, while busy stays high. A refused add, a
// tick that does not complete a second and one that finds the queue empty
// are answered straight from idle. Any other tick runs the head cell
// decrement, then one dequeue shift per woken process, or the idle result.
// Reset empties every cell, clears the tick count and loads 60 ticks per
// second. Results come one per cycle and cannot be held off.
// ----------------------------------------------------------------------------
module delta_timer_queue #(
	parameter int NUM_PROCS = dtq_pkg::NUM_PROCS_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [dtq_pkg::ID_W-1:0]    process_id,
	input  logic [dtq_pkg::WAIT_W-1:0]  wait_seconds,
	output logic                        done,
	output logic [1:0]                  event_kind,
	output logic [dtq_pkg::ID_W-1:0]    woken_id,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [dtq_pkg::TPS_W-1:0]   cfg_wdata
);
	import dtq_pkg::*;

	localparam int IDX_W = $clog2(NUM_PROCS);
	localparam int EXT_W = ID_W + IDX_W;
	localparam int CNT_W = $clog2(NUM_PROCS);
	localparam int WX_W  = WAIT_W + TIME_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;
	localparam logic [1:0] ST_WAKE = 2'd3;

	// chain wiring; index NUM_PROCS is the empty space past the last cell
	tok_ctl_t             tok_ctl  [0:NUM_PROCS];
	logic [ID_W-1:0]      tok_pid  [0:NUM_PROCS];
	logic [TIME_BITS-1:0] tok_time [0:NUM_PROCS];
	logic                 c_valid  [0:NUM_PROCS];
	logic [ID_W-1:0]      c_pid    [0:NUM_PROCS];
	logic [TIME_BITS-1:0] c_delta  [0:NUM_PROCS];
	cell_ctl_t            c_ctl    [0:NUM_PROCS-1];

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TPS_W-1:0]     tps_q;
	logic [TPS_W-1:0]     tick_q;
	logic [NUM_PROCS-1:0] queued_q;

	tok_ctl_t             inj_ctl_q;
	logic [ID_W-1:0]      inj_pid_q;
	logic [TIME_BITS-1:0] inj_time_q;

	logic                 done_q;
	logic [1:0]           kind_q;
	logic [ID_W-1:0]      woken_q;
	logic                 last_q;

	logic                 accept;
	logic [EXT_W-1:0]     pid_ext;
	logic [IDX_W-1:0]     pid_idx;
	logic                 pid_ok;
	logic                 add_ok;
	logic [WX_W-1:0]      wait_ext;
	logic [TIME_BITS-1:0] wait_sat;
	logic [TPS_W-1:0]     tick_nx;
	logic                 head_zero;
	logic                 next_zero;
	logic [EXT_W-1:0]     head_ext;
	logic [IDX_W-1:0]     head_idx;
	logic [EXT_W-1:0]     woken_ext;
	logic [IDX_W-1:0]     woken_idx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// decode the requested process slot
	assign pid_ext = {{IDX_W{1'b0}}, process_id};
	assign pid_idx = pid_ext[IDX_W-1:0];
	assign pid_ok  = (pid_ext < EXT_W'(NUM_PROCS));
	assign add_ok  = pid_ok && !queued_q[pid_idx];

	// zero wait counts as one, long waits saturate
	assign wait_ext = {{TIME_BITS{1'b0}}, wait_seconds};
	always_comb begin
		if (wait_seconds == '0) begin
			wait_sat = TIME_BITS'(1);
		end else if (wait_ext > WX_W'({TIME_BITS{1'b1}})) begin
			wait_sat = '1;
		end else begin
			wait_sat = wait_ext[TIME_BITS-1:0];
		end
	end

	assign tick_nx   = tick_q + TPS_W'(1);
	assign head_zero = c_valid[0] && (c_delta[0] == '0);
	assign next_zero = c_valid[1] && (c_delta[1] == '0);
	assign head_ext  = {{IDX_W{1'b0}}, c_pid[0]};
	assign head_idx  = head_ext[IDX_W-1:0];
	assign woken_ext = {{IDX_W{1'b0}}, woken_q};
	assign woken_idx = woken_ext[IDX_W-1:0];

	// feed the head of the chain and close its tail
	assign tok_ctl[0]          = inj_ctl_q;
	assign tok_pid[0]          = inj_pid_q;
	assign tok_time[0]         = inj_time_q;
	assign c_valid[NUM_PROCS]  = 1'b0;
	assign c_pid[NUM_PROCS]    = '0;
	assign c_delta[NUM_PROCS]  = '0;

	// row of cells
	for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
		assign c_ctl[i].shl = (state_q == ST_WAKE) && head_zero;
		assign c_ctl[i].dec = (i == 0) && (state_q == ST_DEC);

		dtq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (c_ctl[i]),
			.tin_ctl   (tok_ctl[i]),
			.tin_pid   (tok_pid[i]),
			.tin_time  (tok_time[i]),
			.tout_ctl  (tok_ctl[i+1]),
			.tout_pid  (tok_pid[i+1]),
			.tout_time (tok_time[i+1]),
			.nb_valid  (c_valid[i+1]),
			.nb_pid    (c_pid[i+1]),
			.nb_delta  (c_delta[i+1]),
			.valid     (c_valid[i]),
			.pid       (c_pid[i]),
			.delta     (c_delta[i])
		);
	end

	// sequencer, tick counter, queued flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			tps_q     <= TPS_RESET;
			tick_q    <= '0;
			queued_q  <= '0;
			inj_ctl_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			inj_ctl_q <= '0;
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_ADD) begin
							done_q <= 1'b1;
							if (add_ok) begin
								queued_q[pid_idx] <= 1'b1;
								inj_ctl_q.active  <= 1'b1;
								inj_ctl_q.shift   <= 1'b0;
								state_q           <= ST_WALK;
								cnt_q             <= CNT_W'(NUM_PROCS - 1);
							end
						end else if (tick_nx >= tps_q) begin
							tick_q <= '0;
							if (c_valid[0]) begin
								state_q <= ST_DEC;
							end else begin
								done_q <= 1'b1;
							end
						end else begin
							tick_q <= tick_nx;
							done_q <= 1'b1;
						end
					end
				end
				ST_WALK: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DEC: begin
					state_q <= ST_WAKE;
				end
				ST_WAKE: begin
					done_q <= 1'b1;
					if (head_zero) begin
						queued_q[head_idx] <= 1'b0;
						if (!next_zero) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload and insert beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			inj_pid_q  <= process_id;
			inj_time_q <= wait_sat;
		end
		case (state_q)
			ST_IDLE: begin
				woken_q <= '0;
				last_q  <= 1'b1;
				if (opcode == OP_ADD) begin
					kind_q <= add_ok ? KIND_ACC : KIND_REF;
				end else begin
					kind_q <= KIND_NONE;
				end
			end
			ST_WAKE: begin
				if (head_zero) begin
					kind_q  <= KIND_WOKE;
					woken_q <= c_pid[0];
					last_q  <= !next_zero;
				end else begin
					kind_q  <= KIND_NONE;
					woken_q <= '0;
					last_q  <= 1'b1;
				end
			end
			default: begin
				kind_q  <= kind_q;
				woken_q <= woken_q;
				last_q  <= last_q;
			end
		endcase
	end

	assign done       = done_q;
	assign event_kind = kind_q;
	assign woken_id   = woken_q;
	assign last       = last_q;

	// no insert beat may fall off the end of the row
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_ctl[NUM_PROCS].active)
		else $error("insert beat left the last cell");

	// a woken process is no longer marked as waiting
	a_woken_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (kind_q == KIND_WOKE)) |-> !queued_q[woken_idx])
		else $error("woken process still marked queued");

	// the head decrement only runs on a filled head cell
	a_dec_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC) |-> c_valid[0])
		else $error("head decrement on empty queue");

	// a tick that finds no due entry closes with a last beat before going idle
	a_wake_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WAKE) && !head_zero) |=> (done_q && last_q))
		else $error("tick closed without a last beat");

endmodule

### test/delta_timer_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue_test
// Self-checking bench for the delta timer queue. A behavioral copy of the
// delta list tracks every accepted command beat and queues the wake events it
// must cause; each result beat is checked field by field against the oldest
// queued event. A directed opening covers zero waits, refused adds, equal
// expiry ordering, multi-wakes and idle ticks, then random bursts run under
// several tick rates, including the extremes.
// ----------------------------------------------------------------------------
module delta_timer_queue_test;
	import dtq_pkg::*;

	localparam int NPROC = NUM_PROCS_DEF;
	localparam int MAX_WAKES = 16;

	typedef struct packed {
		event_kind_t      kind;
		logic [ID_W-1:0]  id;
		logic             fin;
	} wake_event_t;

	// Delta list shadow plus the wake events still owed by the block
	class sleep_list_tracker;
		logic [TPS_W-1:0]  rate;
		logic [TPS_W-1:0]  tick_cnt;
		logic [WAIT_W-1:0] delta [NPROC];
		logic [ID_W-1:0]   link [NPROC];
		bit                queued [NPROC];
		logic [ID_W-1:0]   head;
		bit                nonempty;
		wake_event_t       owed_events [$];
		int                errors;

		function new();
			rate = TPS_RESET;
			tick_cnt = '0;
			foreach (queued[i]) queued[i] = 1'b0;
			head = '0;
			nonempty = 1'b0;
			errors = 0;
		endfunction

		function wake_event_t make_event(event_kind_t kind, logic [ID_W-1:0] id, logic fin);
			wake_event_t ev;
			ev.kind = kind;
			ev.id = id;
			ev.fin = fin;
			return ev;
		endfunction

		// Walk the list and splice the new sleeper in behind equal expiries
		function bit insert_sleeper(logic [ID_W-1:0] pid, logic [WAIT_W-1:0] secs);
			logic [WAIT_W-1:0] remaining;
			logic [ID_W-1:0]   cur;
			logic [ID_W-1:0]   prev;
			bit                have_cur;
			bit                have_prev;
			int                i;
			if (queued[pid])
				return 1'b0;
			remaining = (secs == '0) ? WAIT_W'(1) : secs;
			cur = head;
			prev = '0;
			have_cur = nonempty;
			have_prev = 1'b0;
			for (i = 0; i < NPROC && have_cur && remaining >= delta[cur]; i++) begin
				remaining -= delta[cur];
				prev = cur;
				have_prev = 1'b1;
				if (link[cur] == cur)
					have_cur = 1'b0;
				else
					cur = link[cur];
			end
			delta[pid] = remaining;
			if (have_cur) begin
				link[pid] = cur;
				delta[cur] -= remaining;
			end else begin
				link[pid] = pid;
			end
			if (have_prev)
				link[prev] = pid;
			else
				head = pid;
			nonempty = 1'b1;
			queued[pid] = 1'b1;
			return 1'b1;
		endfunction

		// Count the tick; on a full second decrement the head and pop zero deltas
		function void advance_tick();
			logic [ID_W-1:0] woken [$];
			logic [ID_W-1:0] h;
			bit              stop;
			tick_cnt++;
			if (tick_cnt >= rate) begin
				tick_cnt = '0;
				if (nonempty) begin
					if (delta[head] != '0)
						delta[head]--;
					stop = 1'b0;
					while (nonempty && !stop && woken.size() < MAX_WAKES) begin
						h = head;
						if (delta[h] != '0) begin
							stop = 1'b1;
						end else begin
							woken.push_back(h);
							queued[h] = 1'b0;
							if (link[h] == h)
								nonempty = 1'b0;
							else
								head = link[h];
						end
					end
				end
			end
			if (woken.size() == 0)
				owed_events.push_back(make_event(KIND_NONE, '0, 1'b1));
			else
				foreach (woken[k])
					owed_events.push_back(make_event(KIND_WOKE, woken[k],
						k == woken.size() - 1));
		endfunction

		function void note_command(opcode_t op, logic [ID_W-1:0] pid, logic [WAIT_W-1:0] secs);
			bit ok;
			if (op == OP_ADD) begin
				ok = insert_sleeper(pid, secs);
				owed_events.push_back(make_event(ok ? KIND_ACC : KIND_REF, '0, 1'b1));
			end else begin
				advance_tick();
			end
		endfunction

		function void check_event(logic [1:0] kind, logic [ID_W-1:0] id, logic fin);
			wake_event_t want;
			if (owed_events.size() == 0) begin
				$display("%0t: result with nothing owed: kind %0d id %0d last %0d",
					$time, kind, id, fin);
				errors++;
				return;
			end
			want = owed_events.pop_front();
			if (kind !== want.kind) begin
				$display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
				errors++;
			end
			if (id !== want.id) begin
				$display("%0t: woken_id expected %0d actual %0d", $time, want.id, id);
				errors++;
			end
			if (fin !== want.fin) begin
				$display("%0t: last expected %0d actual %0d", $time, want.fin, fin);
				errors++;
			end
		endfunction

		function int owed();
			return owed_events.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              opcode = 1'b0;
	logic [ID_W-1:0]   process_id = '0;
	logic [WAIT_W-1:0] wait_seconds = '0;
	logic              done;
	logic [1:0]        event_kind;
	logic [ID_W-1:0]   woken_id;
	logic              last;
	logic              cfg_we = 1'b0;
	logic [TPS_W-1:0]  cfg_wdata = '0;

	sleep_list_tracker tracker;

	delta_timer_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.process_id   (process_id),
		.wait_seconds (wait_seconds),
		.done         (done),
		.event_kind   (event_kind),
		.woken_id     (woken_id),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Check every result beat; the block cannot stall, so no backpressure here
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_event(event_kind, woken_id, last);
	end

	// Present one command beat and hold it until taken
	task automatic issue(opcode_t op, logic [ID_W-1:0] pid, logic [WAIT_W-1:0] secs);
		start <= 1'b1;
		opcode <= op;
		process_id <= pid;
		wait_seconds <= secs;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_command(op, pid, secs);
	endtask

	// Drop start for a gap of the given length
	task automatic hold_off(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait out every owed result, then let the block go fully quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.owed() != 0 || busy)
			@(posedge clk);
		repeat (NPROC + 4) @(posedge clk);
	endtask

	task automatic write_rate(logic [TPS_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.rate = value;
	endtask

	// Random bursts at one tick rate; waits mostly short so entries expire
	task automatic run_phase(logic [TPS_W-1:0] value, int count, int tick_pct, int max_wait);
		int                sent;
		int                burst;
		int                k;
		int                roll;
		opcode_t           op;
		logic [ID_W-1:0]   pid;
		logic [WAIT_W-1:0] secs;
		drain();
		write_rate(value);
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < count; k++) begin
				op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_ADD;
				pid = $urandom_range(NPROC - 1);
				if ($urandom_range(99) < 2)
					secs = $urandom_range(16'hFFFF);
				else
					secs = $urandom_range(max_wait);
				issue(op, pid, secs);
				sent++;
			end
			roll = $urandom_range(9);
			if (roll == 0)
				drain();
			else if (roll >= 4)
				hold_off($urandom_range(1, 24));
		end
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at one tick per second
		write_rate(8'd1);
		issue(OP_ADD, 4'd3, 16'd0);       // zero wait counts as one second
		issue(OP_ADD, 4'd3, 16'd5);       // already sleeping: refused
		issue(OP_ADD, 4'd7, 16'd1);       // equal expiry lands behind 3
		issue(OP_ADD, 4'd0, 16'd2);
		issue(OP_ADD, 4'd10, 16'd2);
		issue(OP_ADD, 4'd15, 16'hFFFF);   // longest wait
		issue(OP_ADD, 4'd8, 16'd1);
		issue(OP_TICK, 4'd15, 16'hFFFF);  // wakes 3, 7, 8
		issue(OP_TICK, 4'd0, 16'd0);      // wakes 0, 10
		issue(OP_ADD, 4'd5, 16'd3);
		issue(OP_ADD, 4'd6, 16'd1);       // new head in front of 5
		issue(OP_TICK, 4'd0, 16'd0);
		issue(OP_TICK, 4'd0, 16'd0);      // nothing due
		issue(OP_TICK, 4'd0, 16'd0);
		issue(OP_TICK, 4'd0, 16'd0);
		issue(OP_ADD, 4'd3, 16'd1);       // freed id is accepted again

		run_phase(8'd60, 90, 92, 1);
		run_phase(8'd0, 50, 50, 5);
		run_phase(8'd255, 40, 70, 1);
		run_phase(8'd2, 60, 60, 4);
		run_phase(8'd1, 60, 50, 8);
		run_phase(8'd3, 60, 65, 3);
		drain();

		if (tracker.errors == 0)
			$display("delta_timer_queue verification clean");
		else
			$display("delta_timer_queue verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("delta_timer_queue verification failed");
		$finish;
	end

endmodule
